[sv/qrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_pkg
// Shared types and constants of the quorum reply tracker.
// ----------------------------------------------------------------------------
package qrt_pkg;

	localparam int ID_W     = 16;
	localparam int KIND_W   = 2;
	localparam int MODE_W   = 2;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 2;
	localparam int QUORUM_W = 2;
	localparam int TOUT_W   = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_RESULTS = 16;
	localparam int NRES_W      = $clog2(MAX_RESULTS);

	localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPLY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_QUORUM  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

	localparam logic [QUORUM_W-1:0] QUORUM_RST  = 2'd2;
	localparam logic [TOUT_W-1:0]   TIMEOUT_RST = 16'd5;

	localparam logic [CNT_W-1:0] COUNT_MAX = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_ADDR,
		ST_REPLY,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [QUORUM_W-1:0] quorum;
		logic [TOUT_W-1:0]   timeout;
	} cfg_t;

	typedef struct packed {
		logic open;
		logic bump;
		logic rd;
		logic mark_done;
	} store_ctl_t;

endpackage

[sv/qrt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_if
// Request, response and configuration channels of the quorum reply tracker.
// ----------------------------------------------------------------------------
interface qrt_req_if;
	logic                      valid;
	logic                      ready;
	logic [qrt_pkg::MODE_W-1:0] mode;
	logic [qrt_pkg::ID_W-1:0]   trans_id;
	logic [qrt_pkg::KIND_W-1:0] op_kind;
	logic [qrt_pkg::TIME_W-1:0] now;

	modport source (output valid, output mode, output trans_id, output op_kind,
		output now, input ready);
	modport sink (input valid, input mode, input trans_id, input op_kind,
		input now, output ready);
endinterface

interface qrt_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [qrt_pkg::ID_W-1:0]   done_id;
	logic [qrt_pkg::KIND_W-1:0] done_kind;
	logic                      success;
	logic                      last;

	modport source (output valid, output done_id, output done_kind, output success,
		output last, input ready);
	modport sink (input valid, input done_id, input done_kind, input success,
		input last, output ready);
endinterface

interface qrt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [qrt_pkg::CFG_IDX_W-1:0]  index;
	logic [qrt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/qrt_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_store
// Slot table: tag, kind, start time and reply count memories with a
// registered read port, plus valid and done flags in flip-flops.
// ----------------------------------------------------------------------------
module qrt_store #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qrt_pkg::store_ctl_t           ctl,
	input  logic [$clog2(SLOTS)-1:0]      wr_addr,
	input  logic [$clog2(SLOTS)-1:0]      rd_addr,
	input  logic [$clog2(SLOTS)-1:0]      fl_addr,
	input  logic [qrt_pkg::ID_W-1:0]      wr_tag,
	input  logic [qrt_pkg::KIND_W-1:0]    wr_kind,
	input  logic [qrt_pkg::TIME_W-1:0]    wr_start,
	input  logic [qrt_pkg::CNT_W-1:0]     wr_count,
	output logic [qrt_pkg::ID_W-1:0]      rd_tag,
	output logic [qrt_pkg::KIND_W-1:0]    rd_kind,
	output logic [qrt_pkg::TIME_W-1:0]    rd_start,
	output logic [qrt_pkg::CNT_W-1:0]     rd_count,
	output logic                          fl_valid,
	output logic                          fl_done
);
	import qrt_pkg::*;

	logic [ID_W-1:0]   tag_mem   [SLOTS];
	logic [KIND_W-1:0] kind_mem  [SLOTS];
	logic [TIME_W-1:0] start_mem [SLOTS];
	logic [CNT_W-1:0]  count_mem [SLOTS];

	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] done_q;

	always_ff @(posedge clk) begin
		if (ctl.open) begin
			tag_mem[wr_addr]   <= wr_tag;
			kind_mem[wr_addr]  <= wr_kind;
			start_mem[wr_addr] <= wr_start;
		end
		if (ctl.open || ctl.bump) begin
			count_mem[wr_addr] <= wr_count;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_tag   <= tag_mem[rd_addr];
			rd_kind  <= kind_mem[rd_addr];
			rd_start <= start_mem[rd_addr];
			rd_count <= count_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= '0;
		end else begin
			if (ctl.open) begin
				valid_q[wr_addr] <= 1'b1;
				done_q[wr_addr]  <= 1'b0;
			end else if (ctl.mark_done) begin
				done_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign fl_valid = valid_q[fl_addr];
	assign fl_done  = done_q[fl_addr];

endmodule

[sv/qrt_judge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_judge
// Shared compare unit: quorum check and wrapping elapsed-time timeout check
// for the slot currently under evaluation.
// ----------------------------------------------------------------------------
module qrt_judge (
	input  qrt_pkg::cfg_t                cfg_val,
	input  logic [qrt_pkg::CNT_W-1:0]    count,
	input  logic [qrt_pkg::TIME_W-1:0]   start,
	input  logic [qrt_pkg::TIME_W-1:0]   now,
	output logic                         met,
	output logic                         expired
);
	import qrt_pkg::*;

	logic [TIME_W-1:0] elapsed;

	assign elapsed = now - start;
	assign met     = count >= cfg_val.quorum;
	assign expired = elapsed >= TIME_W'(cfg_val.timeout);

endmodule

[sv/quorum_reply_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quorum_reply_tracker
// Tracks open requests in a slot table, counts matching replies and, on a
// tick, reports each pending slot that reached quorum or timed out.
//
//   channel  dir  payload                               transfer
//   req      in   mode, trans_id, op_kind, now          valid & ready
//   rsp      out  done_id, done_kind, success, last     valid & ready
//   cfg      in   index, data                           valid & ready
//
// open and reply: slot index by a reciprocal multiply, then a registered
// table read for replies; an unused mode returns straight to idle.
// tick: one slot per cycle through the table read port and the shared
// compare unit, except while rsp holds a result back.
// req is ready only in idle; cfg is always ready. No clearing pass after
// reset: valid and done flags are flip-flops.
// ----------------------------------------------------------------------------
module quorum_reply_tracker #(
	parameter int SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	qrt_req_if.sink    req,
	qrt_rsp_if.source  rsp,
	qrt_cfg_if.sink    cfg
);
	import qrt_pkg::*;

	localparam int IW    = $clog2(SLOTS);
	localparam int SH    = ID_W + IW;
	localparam int RCP_W = ID_W + 2;
	localparam int PRD_W = ID_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << SH) + SLOTS - 1) / SLOTS);
	localparam logic [ID_W-1:0]  SLOTS_ID = ID_W'(SLOTS);
	localparam logic [IW:0]      SLOTS_CNT = (IW + 1)'(SLOTS);

	state_t st_q, st_nxt;

	cfg_t cfg_q;

	logic [ID_W-1:0]   id_q;
	logic [KIND_W-1:0] kind_q;
	logic [TIME_W-1:0] now_q;
	logic              is_open_q;
	logic [ID_W-1:0]   quot_q;

	logic [IW:0]       iss_q;
	logic              v_s1;
	logic [IW-1:0]     idx_s1;
	logic [NRES_W-1:0] nres_q;

	logic              held_v_q;
	logic [ID_W-1:0]   held_id_q;
	logic [KIND_W-1:0] held_kind_q;
	logic              held_ok_q;

	logic              out_v_q;
	logic [ID_W-1:0]   out_id_q;
	logic [KIND_W-1:0] out_kind_q;
	logic              out_ok_q;
	logic              out_last_q;

	store_ctl_t        ctl;
	logic [IW-1:0]     wr_addr;
	logic [IW-1:0]     rd_addr;
	logic [ID_W-1:0]   rd_tag;
	logic [KIND_W-1:0] rd_kind;
	logic [TIME_W-1:0] rd_start;
	logic [CNT_W-1:0]  rd_count;
	logic              fl_valid;
	logic              fl_done;
	logic              met;
	logic              expired;

	logic [PRD_W-1:0]  prod;
	logic [ID_W-1:0]   rem_raw;
	logic [ID_W-1:0]   rem_fix;
	logic [IW-1:0]     slot_c;

	logic              req_acc;
	logic              req_rdy;
	logic              out_free;
	logic              fin;
	logic              stall;
	logic              advance;
	logic              load_out;
	logic              load_last;

	// slot = id mod SLOTS by reciprocal multiply, then correction
	assign prod    = PRD_W'(id_q) * PRD_W'(RECIP);
	assign rem_raw = id_q - ID_W'(quot_q * SLOTS_ID);
	assign rem_fix = (rem_raw >= SLOTS_ID) ? (rem_raw - SLOTS_ID) : rem_raw;
	assign slot_c  = rem_fix[IW-1:0];

	qrt_store #(
		.SLOTS (SLOTS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.fl_addr  (idx_s1),
		.wr_tag   (id_q),
		.wr_kind  (kind_q),
		.wr_start (now_q),
		.wr_count (is_open_q ? '0 : rd_count + CNT_W'(1)),
		.rd_tag   (rd_tag),
		.rd_kind  (rd_kind),
		.rd_start (rd_start),
		.rd_count (rd_count),
		.fl_valid (fl_valid),
		.fl_done  (fl_done)
	);

	qrt_judge u_judge (
		.cfg_val (cfg_q),
		.count   (rd_count),
		.start   (rd_start),
		.now     (now_q),
		.met     (met),
		.expired (expired)
	);

	assign req_acc  = req.valid && req_rdy;
	assign out_free = !out_v_q || rsp.ready;
	assign fin      = v_s1 && fl_valid && !fl_done && (met || expired);
	assign stall    = fin && held_v_q && !out_free;

	always_comb begin
		st_nxt    = st_q;
		req_rdy   = 1'b0;
		ctl       = '0;
		wr_addr   = idx_s1;
		rd_addr   = iss_q[IW-1:0];
		advance   = 1'b0;
		load_out  = 1'b0;
		load_last = 1'b0;
		case (st_q)
			ST_IDLE: begin
				req_rdy = 1'b1;
				if (req.valid) begin
					case (req.mode)
						MODE_OPEN, MODE_REPLY: st_nxt = ST_HASH;
						MODE_TICK:             st_nxt = ST_SCAN;
						default:               st_nxt = ST_IDLE;
					endcase
				end
			end
			ST_HASH: begin
				st_nxt = ST_ADDR;
			end
			ST_ADDR: begin
				if (is_open_q) begin
					ctl.open = 1'b1;
					wr_addr  = slot_c;
					st_nxt   = ST_IDLE;
				end else begin
					ctl.rd  = 1'b1;
					rd_addr = slot_c;
					st_nxt  = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (fl_valid && rd_tag == id_q && rd_count != COUNT_MAX) begin
					ctl.bump = 1'b1;
				end
				st_nxt = ST_IDLE;
			end
			ST_SCAN: begin
				if (!stall) begin
					advance = 1'b1;
					ctl.rd  = iss_q < SLOTS_CNT;
					if (fin) begin
						ctl.mark_done = 1'b1;
						load_out      = held_v_q;
					end
					if ((fin && nres_q == NRES_W'(MAX_RESULTS - 1)) || iss_q == SLOTS_CNT) begin
						st_nxt = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!held_v_q) begin
					st_nxt = ST_IDLE;
				end else if (out_free) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					st_nxt    = ST_IDLE;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quorum  <= QUORUM_RST;
			cfg_q.timeout <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_QUORUM:  cfg_q.quorum  <= cfg.data[QUORUM_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= cfg.data[TOUT_W-1:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	// request capture and slot index
	always_ff @(posedge clk) begin
		if (req_acc) begin
			id_q      <= req.trans_id;
			kind_q    <= req.op_kind;
			now_q     <= req.now;
			is_open_q <= req.mode == MODE_OPEN;
		end
		if (st_q == ST_HASH) begin
			quot_q <= ID_W'(prod >> SH);
		end
	end

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q    <= '0;
			v_s1     <= 1'b0;
			nres_q   <= '0;
			held_v_q <= 1'b0;
		end else begin
			if (req_acc && req.mode == MODE_TICK) begin
				iss_q    <= '0;
				v_s1     <= 1'b0;
				nres_q   <= '0;
				held_v_q <= 1'b0;
			end else if (advance) begin
				v_s1 <= iss_q < SLOTS_CNT;
				if (iss_q < SLOTS_CNT) begin
					iss_q <= iss_q + (IW + 1)'(1);
				end
				if (fin) begin
					held_v_q <= 1'b1;
					nres_q   <= nres_q + NRES_W'(1);
				end
			end else if (st_q == ST_FLUSH && load_out) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_ADDR && !is_open_q) begin
			idx_s1 <= slot_c;
		end else if (advance) begin
			idx_s1 <= iss_q[IW-1:0];
		end
		if (advance && fin) begin
			held_id_q   <= rd_tag;
			held_kind_q <= rd_kind;
			held_ok_q   <= met;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_id_q   <= held_id_q;
			out_kind_q <= held_kind_q;
			out_ok_q   <= held_ok_q;
			out_last_q <= load_last;
		end
	end

	assign req.ready     = req_rdy;
	assign cfg.ready     = 1'b1;
	assign rsp.valid     = out_v_q;
	assign rsp.done_id   = out_id_q;
	assign rsp.done_kind = out_kind_q;
	assign rsp.success   = out_ok_q;
	assign rsp.last      = out_last_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quorum reply tracker. Opens, replies, ticks
// and unused requests go in through a queued driver. A local copy of the slot
// table works out which slots each tick finishes. Every response is checked
// in order against that list. The run covers several quorum and timeout
// settings, random idling on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import qrt_pkg::*;

	localparam int SLOTS       = 16;
	localparam int SCAN_SLACK  = SLOTS + 8;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 57;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0]   id;
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] now;
	} req_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [KIND_W-1:0] kind;
		logic              ok;
		logic              last;
	} finish_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	qrt_req_if req_bus ();
	qrt_rsp_if rsp_bus ();
	qrt_cfg_if cfg_bus ();

	quorum_reply_tracker #(.SLOTS(SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always #4 clk = ~clk;

	// local copy of the slot table and registers
	logic                tbl_valid [SLOTS] = '{default: 1'b0};
	logic                tbl_done  [SLOTS] = '{default: 1'b0};
	logic [ID_W-1:0]     tbl_tag   [SLOTS];
	logic [KIND_W-1:0]   tbl_kind  [SLOTS];
	logic [TIME_W-1:0]   tbl_start [SLOTS];
	logic [CNT_W-1:0]    tbl_count [SLOTS];
	logic [QUORUM_W-1:0] q_need  = QUORUM_RST;
	logic [TOUT_W-1:0]   t_limit = TIMEOUT_RST;

	finish_t   finish_q [$];
	req_item_t req_backlog [$];
	req_item_t next_req;
	logic [ID_W-1:0]   live_ids [$];
	logic [TIME_W-1:0] t_now = '0;

	int  n_queued      = 0;
	int  n_accepted    = 0;
	int  err_cnt       = 0;
	int  quiet_cycles  = 0;
	int  src_idle_pct  = 0;
	int  snk_stall_pct = 0;
	int  hold_left     = 0;
	bit  hold_armed    = 1'b0;
	bit  hold_used     = 1'b0;
	logic req_taken    = 1'b0;

	function automatic void track_request(input req_item_t it);
		int          s;
		logic        hit;
		logic        ok;
		logic        have_held;
		finish_t     held;
		logic [TIME_W-1:0] elapsed;
		s = int'(it.id) % SLOTS;
		have_held = 1'b0;
		held = '0;
		case (it.mode)
			MODE_OPEN: begin
				tbl_valid[s] = 1'b1;
				tbl_done[s]  = 1'b0;
				tbl_tag[s]   = it.id;
				tbl_kind[s]  = it.kind;
				tbl_start[s] = it.now;
				tbl_count[s] = '0;
			end
			MODE_REPLY: begin
				if (tbl_valid[s] && tbl_tag[s] == it.id && tbl_count[s] != COUNT_MAX)
					tbl_count[s] = tbl_count[s] + 1'b1;
			end
			MODE_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					hit = 1'b0;
					ok  = 1'b0;
					if (tbl_valid[i] && !tbl_done[i]) begin
						elapsed = it.now - tbl_start[i];
						if (tbl_count[i] >= q_need) begin
							hit = 1'b1;
							ok  = 1'b1;
						end else if (elapsed >= {16'd0, t_limit}) begin
							hit = 1'b1;
						end
					end
					if (hit) begin
						tbl_done[i] = 1'b1;
						if (have_held)
							finish_q.insert(finish_q.size(), held);
						held = '{tbl_tag[i], tbl_kind[i], ok, 1'b0};
						have_held = 1'b1;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					finish_q.insert(finish_q.size(), held);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_fault(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid    <= 1'b0;
			req_bus.mode     <= MODE_OPEN;
			req_bus.trans_id <= '0;
			req_bus.op_kind  <= KIND_READ;
			req_bus.now      <= '0;
		end else if (!req_bus.valid || req_taken) begin
			if (req_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				next_req = req_backlog.pop_front();
				req_bus.valid    <= 1'b1;
				req_bus.mode     <= next_req.mode;
				req_bus.trans_id <= next_req.id;
				req_bus.op_kind  <= next_req.kind;
				req_bus.now      <= next_req.now;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// response ready, with one long hold-off when armed
	always @(negedge clk) begin
		if (hold_armed && !hold_used) begin
			hold_left = HOLD_CYCLES;
			hold_used = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= arst_n && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		req_taken <= req_bus.valid && req_bus.ready;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (finish_q.size() == 0) begin
					report_fault($sformatf("unexpected result id %h kind %0d ok %0b last %0b",
						rsp_bus.done_id, rsp_bus.done_kind, rsp_bus.success, rsp_bus.last));
				end else begin
					finish_t want;
					want = finish_q.pop_front();
					if (rsp_bus.done_id !== want.id || rsp_bus.done_kind !== want.kind ||
							rsp_bus.success !== want.ok || rsp_bus.last !== want.last)
						report_fault($sformatf(
							"mismatch: exp %h/%0d/%0b/%0b got %h/%0d/%0b/%0b",
							want.id, want.kind, want.ok, want.last, rsp_bus.done_id,
							rsp_bus.done_kind, rsp_bus.success, rsp_bus.last));
				end
			end
			if (cfg_bus.valid && cfg_bus.ready) begin
				if (cfg_bus.index == REG_QUORUM)
					q_need = cfg_bus.data[QUORUM_W-1:0];
				else if (cfg_bus.index == REG_TIMEOUT)
					t_limit = cfg_bus.data[TOUT_W-1:0];
			end
			if (req_bus.valid && req_bus.ready) begin
				track_request(req_item_t'{req_bus.mode, req_bus.trans_id, req_bus.op_kind,
					req_bus.now});
				n_accepted++;
			end
			if ((rsp_bus.valid && rsp_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
					(req_bus.valid && req_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles, %0d results outstanding",
					quiet_cycles, finish_q.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic push_req(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
			input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t);
		req_backlog.insert(req_backlog.size(), req_item_t'{m, id, k, t});
		n_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || finish_q.size() != 0)
			@(negedge clk);
		repeat (SCAN_SLACK) @(posedge clk);
	endtask

	task automatic queue_directed();
		// fill every slot first so no request touches an unwritten entry
		push_req(MODE_OPEN, 16'h0000, KIND_READ, 32'h0000_0000);
		push_req(MODE_OPEN, 16'hFFFF, KIND_BAD, 32'hFFFF_FFFF);
		for (int i = 1; i < SLOTS - 1; i++)
			push_req(MODE_OPEN, {12'(i * 331 + 7), 4'(i)}, KIND_W'(i % 3), 32'd100);
		// four replies: count saturates instead of wrapping
		repeat (4) push_req(MODE_REPLY, 16'h0000, KIND_UPDATE, 32'h0000_0000);
		// same slot, other tag: ignored
		push_req(MODE_REPLY, 16'h0010, KIND_DELETE, 32'h0000_0000);
		push_req(MODE_UNUSED, 16'hFFFF, KIND_BAD, 32'hFFFF_FFFF);
		// slot 0 succeeds, slots opened at 100 see a wrapped elapsed time
		push_req(MODE_TICK, 16'h0000, KIND_READ, 32'd2);
		// reply to a finished slot
		push_req(MODE_REPLY, 16'h0000, KIND_READ, 32'd2);
		// quiet tick, then the wrapped slot times out
		push_req(MODE_TICK, 16'h0000, KIND_READ, 32'd3);
		push_req(MODE_TICK, 16'hFFFF, KIND_BAD, 32'd4);
		t_now = 32'd4;
	endtask

	task automatic queue_random(input int count);
		int made;
		int roll;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] step;
		made = 0;
		while (made < count) begin
			roll = $urandom_range(99);
			if (roll < 35) begin
				id = ID_W'($urandom);
				t_now += TIME_W'($urandom_range(1));
				push_req(MODE_OPEN, id, KIND_W'($urandom), t_now);
				live_ids.insert(live_ids.size(), id);
				if (live_ids.size() > 12)
					void'(live_ids.pop_front());
				made++;
			end else if (roll < 70) begin
				if (live_ids.size() > 0 && $urandom_range(9) < 8)
					id = live_ids[$urandom_range(live_ids.size() - 1)];
				else
					id = ID_W'($urandom);
				push_req(MODE_REPLY, id, KIND_W'($urandom), TIME_W'($urandom));
				made++;
			end else if (roll < 95) begin
				roll = $urandom_range(99);
				if (roll < 85)
					step = TIME_W'($urandom_range(3));
				else if (roll < 97)
					step = TIME_W'($urandom_range(70000, 60000));
				else
					step = TIME_W'($urandom);
				t_now += step;
				push_req(MODE_TICK, ID_W'($urandom), KIND_W'($urandom), t_now);
				made++;
			end else begin
				push_req(MODE_UNUSED, ID_W'($urandom), KIND_W'($urandom), TIME_W'($urandom));
			end
		end
	endtask

	task automatic run_phase(input logic [QUORUM_W-1:0] q, input logic [TOUT_W-1:0] t,
			input int src_pct, input int snk_pct, input logic [TIME_W-1:0] base,
			input bit pressure);
		wait_drained();
		write_reg(REG_QUORUM, {14'($urandom), q});
		write_reg(REG_TIMEOUT, t);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		t_now = base;
		if (pressure) begin
			// stale opens so the first tick has results to back up
			repeat (3)
				push_req(MODE_OPEN, ID_W'($urandom), KIND_W'($urandom), t_now - 32'd100);
			push_req(MODE_TICK, ID_W'($urandom), KIND_W'($urandom), t_now);
			hold_armed = 1'b1;
		end
		queue_random(PHASE_ITEMS);
	endtask

	initial begin
		cfg_bus.valid    = 1'b0;
		cfg_bus.index    = REG_QUORUM;
		cfg_bus.data     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_directed();
		run_phase(2'd1, 16'd1, 66, 0, TIME_W'($urandom), 1'b0);
		run_phase(2'd3, 16'hFFFF, 0, 66, TIME_W'($urandom), 1'b0);
		run_phase(2'd0, 16'd0, 11, 11, TIME_W'($urandom), 1'b0);
		run_phase(2'd2, 16'd20, 0, 0, TIME_W'($urandom), 1'b1);
		run_phase(2'd3, 16'd3, 11, 11, 32'hFFFF_FFF0, 1'b0);
		wait_drained();

		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
